// ----- hdl/cramer_3x3_linear_solve_core_defines.svh -----
// assertion macros for the cramer 3x3 solver
`ifndef CRAMER_3X3_LINEAR_SOLVE_CORE_DEFINES_SVH
`define CRAMER_3X3_LINEAR_SOLVE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define C3LS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3ls assertion failed");
// antecedent implies consequent in the next cycle
`define C3LS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3ls assertion failed");
`else
`define C3LS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define C3LS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/c3ls_pkg.sv -----
package c3ls_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int THR_W   = 31;
    // 2x2 cofactor, 3x3 term and sum widths
    localparam int COF_W   = 2 * DATA_W + 1;
    localparam int PROD_W  = COF_W + DATA_W + 1;
    localparam int NUM_W   = PROD_W + 2;
    // fraction bits of q16.16
    localparam int FRAC_W  = 16;
    // quotient bits produced by the divider
    localparam int DIV_STEPS = DATA_W;
    localparam int REM_W   = NUM_W + DIV_STEPS;
    // products, sums, abs, setup, divide steps, output
    localparam int STAGES  = 7 + DIV_STEPS + 1;
    // number of 3x3 terms
    localparam int N_TERMS = 12;

    localparam logic STATUS_SOLVED   = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

endpackage

// ----- hdl/c3ls_in_if.sv -----
interface c3ls_in_if;
    logic valid;
    logic ready;
    logic signed [c3ls_pkg::DATA_W-1:0] m11;
    logic signed [c3ls_pkg::DATA_W-1:0] m12;
    logic signed [c3ls_pkg::DATA_W-1:0] m13;
    logic signed [c3ls_pkg::DATA_W-1:0] m21;
    logic signed [c3ls_pkg::DATA_W-1:0] m22;
    logic signed [c3ls_pkg::DATA_W-1:0] m23;
    logic signed [c3ls_pkg::DATA_W-1:0] m31;
    logic signed [c3ls_pkg::DATA_W-1:0] m32;
    logic signed [c3ls_pkg::DATA_W-1:0] m33;
    logic signed [c3ls_pkg::DATA_W-1:0] rhs1;
    logic signed [c3ls_pkg::DATA_W-1:0] rhs2;
    logic signed [c3ls_pkg::DATA_W-1:0] rhs3;

    modport source (
        output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, rhs1, rhs2, rhs3,
        input  ready
    );
    modport sink (
        input  valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, rhs1, rhs2, rhs3,
        output ready
    );
endinterface

// ----- hdl/c3ls_out_if.sv -----
interface c3ls_out_if;
    logic valid;
    logic ready;
    logic signed [c3ls_pkg::DATA_W-1:0] sol1;
    logic signed [c3ls_pkg::DATA_W-1:0] sol2;
    logic signed [c3ls_pkg::DATA_W-1:0] sol3;
    logic status;

    modport source (output valid, sol1, sol2, sol3, status, input ready);
    modport sink (input valid, sol1, sol2, sol3, status, output ready);
endinterface

// ----- hdl/c3ls_cfg_if.sv -----
interface c3ls_cfg_if;
    logic valid;
    logic ready;
    logic [c3ls_pkg::THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/cramer_3x3_linear_solve_core.sv -----
// 3x3 linear system solver by cramer's rule, signed q16.16 in and out.
// i_in carries the nine matrix entries and three right-hand entries; one
// transfer is one system. o_out carries sol1..sol3 and status (1 = singular,
// solutions zero). i_cfg writes the singularity threshold (reset value 1);
// it is always ready and should be written only while the pipe is empty.
// The pipe has 40 register stages: 7 stages of multiply, cofactor, partial
// product, combine, sum, abs and divider setup, then 32 restoring divide
// stages (one quotient bit each, three dividers in parallel), then the
// saturating output register.
// Throughput is one system per cycle; the pipe moves as one, and a new
// system enters every cycle the output register is empty or being taken.
// When the receiver stalls with a result waiting, the whole pipe holds and
// i_in.ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and sets the threshold to 1.
`include "cramer_3x3_linear_solve_core_defines.svh"

module cramer_3x3_linear_solve_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    c3ls_in_if.sink           i_in,
    c3ls_out_if.source        o_out,
    c3ls_cfg_if.sink          i_cfg
);
    localparam int DATA_W    = c3ls_pkg::DATA_W;
    localparam int THR_W     = c3ls_pkg::THR_W;
    localparam int COF_W     = c3ls_pkg::COF_W;
    localparam int PROD_W    = c3ls_pkg::PROD_W;
    localparam int NUM_W     = c3ls_pkg::NUM_W;
    localparam int FRAC_W    = c3ls_pkg::FRAC_W;
    localparam int DIV_STEPS = c3ls_pkg::DIV_STEPS;
    localparam int REM_W     = c3ls_pkg::REM_W;
    localparam int STAGES    = c3ls_pkg::STAGES;
    localparam int N_TERMS   = c3ls_pkg::N_TERMS;
    localparam int PP_W      = DATA_W + DATA_W + 1;

    typedef logic signed [DATA_W-1:0]   t_word;
    typedef logic signed [2*DATA_W-1:0] t_p2;
    typedef logic signed [COF_W-1:0]    t_cof;
    typedef logic signed [PP_W-1:0]     t_pp;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [NUM_W-1:0]    t_num;

    logic              w_en;
    logic [STAGES-1:0] r_vld;
    logic [THR_W-1:0]  r_thr;

    // threshold register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_thr <= i_cfg.data;
        end
    end

    // pipe advances unless a result waits untaken
    assign w_en       = !r_vld[STAGES-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_in.valid};
        end
    end

    // stage 1: 32x32 products for the 2x2 cofactors
    t_p2   r_p1 [14];
    t_word r1_a11, r1_a12, r1_a13, r1_b1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1[0]  <= i_in.m22 * i_in.m33;
            r_p1[1]  <= i_in.m23 * i_in.m32;
            r_p1[2]  <= i_in.m21 * i_in.m33;
            r_p1[3]  <= i_in.m23 * i_in.m31;
            r_p1[4]  <= i_in.m21 * i_in.m32;
            r_p1[5]  <= i_in.m22 * i_in.m31;
            r_p1[6]  <= i_in.rhs2 * i_in.m33;
            r_p1[7]  <= i_in.rhs3 * i_in.m23;
            r_p1[8]  <= i_in.rhs2 * i_in.m32;
            r_p1[9]  <= i_in.rhs3 * i_in.m22;
            r_p1[10] <= i_in.m21 * i_in.rhs3;
            r_p1[11] <= i_in.m31 * i_in.rhs2;
            r_p1[12] <= i_in.m22 * i_in.rhs3;
            r_p1[13] <= i_in.m32 * i_in.rhs2;
            r1_a11   <= i_in.m11;
            r1_a12   <= i_in.m12;
            r1_a13   <= i_in.m13;
            r1_b1    <= i_in.rhs1;
        end
    end

    // stage 2: cofactor differences c1..c3, u1..u4
    t_cof  r_cof [7];
    t_word r2_a11, r2_a12, r2_a13, r2_b1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 7; k++) begin
                r_cof[k] <= {r_p1[2*k][2*DATA_W-1], r_p1[2*k]}
                          - {r_p1[2*k+1][2*DATA_W-1], r_p1[2*k+1]};
            end
            r2_a11 <= r1_a11;
            r2_a12 <= r1_a12;
            r2_a13 <= r1_a13;
            r2_b1  <= r1_b1;
        end
    end

    // stage 3: split 32x65 products into two partial products
    // cofactor order: c1 c2 c3 u1 u2 u3 u4
    t_word w_mx [N_TERMS];
    t_cof  w_my [N_TERMS];
    t_pp   r_pplo [N_TERMS];
    t_pp   r_pphi [N_TERMS];
    always_comb begin
        // det = a11 c1 - a12 c2 + a13 c3
        w_mx[0]  = r2_a11; w_my[0]  = r_cof[0];
        w_mx[1]  = r2_a12; w_my[1]  = r_cof[1];
        w_mx[2]  = r2_a13; w_my[2]  = r_cof[2];
        // column 1 = b1 c1 - a12 u1 + a13 u2
        w_mx[3]  = r2_b1;  w_my[3]  = r_cof[0];
        w_mx[4]  = r2_a12; w_my[4]  = r_cof[3];
        w_mx[5]  = r2_a13; w_my[5]  = r_cof[4];
        // column 2 = a11 u1 - b1 c2 + a13 u3
        w_mx[6]  = r2_a11; w_my[6]  = r_cof[3];
        w_mx[7]  = r2_b1;  w_my[7]  = r_cof[1];
        w_mx[8]  = r2_a13; w_my[8]  = r_cof[5];
        // column 3 = a11 u4 - a12 u3 + b1 c3
        w_mx[9]  = r2_a11; w_my[9]  = r_cof[6];
        w_mx[10] = r2_a12; w_my[10] = r_cof[5];
        w_mx[11] = r2_b1;  w_my[11] = r_cof[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_TERMS; k++) begin
                r_pplo[k] <= w_mx[k] * $signed({1'b0, w_my[k][DATA_W-1:0]});
                r_pphi[k] <= w_mx[k] * $signed(w_my[k][COF_W-1:DATA_W]);
            end
        end
    end

    // stage 4: combine partial products
    t_prod r_prod [N_TERMS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_TERMS; k++) begin
                r_prod[k] <= $signed({r_pphi[k][PP_W-1], r_pphi[k], {DATA_W{1'b0}}})
                           + $signed({{(PROD_W-PP_W){r_pplo[k][PP_W-1]}}, r_pplo[k]});
            end
        end
    end

    // stage 5: determinant and the three column determinants
    t_num r_sum [4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= {{2{r_prod[3*j][PROD_W-1]}}, r_prod[3*j]}
                          - {{2{r_prod[3*j+1][PROD_W-1]}}, r_prod[3*j+1]}
                          + {{2{r_prod[3*j+2][PROD_W-1]}}, r_prod[3*j+2]};
            end
        end
    end

    // stage 6: magnitudes and signs
    logic [NUM_W-1:0] r_mag [4];
    logic [3:0]       r_sgn;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 4; j++) begin
                r_mag[j] <= r_sum[j][NUM_W-1] ? NUM_W'(0) - r_sum[j] : r_sum[j];
                r_sgn[j] <= r_sum[j][NUM_W-1];
            end
        end
    end

    // divider pipe state, index 0 is setup, index s+1 after step s
    logic [REM_W-1:0]  r_rem [DIV_STEPS+1][3];
    logic [DATA_W-1:0] r_q   [DIV_STEPS+1][3];
    logic [NUM_W-1:0]  r_dd  [DIV_STEPS+1];
    logic [2:0]        r_neg [DIV_STEPS+1];
    logic [2:0]        r_ovf [DIV_STEPS+1];
    logic              r_sng [DIV_STEPS+1];

    // stage 7: singular test, overflow test, dividend setup
    logic n_sng;
    always_comb begin
        n_sng = (r_mag[0] == '0)
             || ((r_mag[0][NUM_W-1:THR_W+DATA_W] == '0)
                 && (r_mag[0][THR_W+DATA_W-1:DATA_W] < r_thr));
    end

    // quotient needs more than 32 bits when num >= den * 2^16
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= {{(REM_W-NUM_W-FRAC_W){1'b0}}, r_mag[k+1], {FRAC_W{1'b0}}};
                r_q[0][k]   <= '0;
                r_neg[0][k] <= r_sgn[k+1] ^ r_sgn[0];
                r_ovf[0][k] <= {{FRAC_W{1'b0}}, r_mag[k+1]}
                               >= {r_mag[0], {FRAC_W{1'b0}}};
            end
            r_dd[0]  <= r_mag[0];
            r_sng[0] <= n_sng;
        end
    end

    // stages 8..39: one restoring quotient bit per stage, three dividers
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - s;
        logic [REM_W-1:0] w_dsh;
        assign w_dsh = {{(REM_W-NUM_W){1'b0}}, r_dd[s]} << BIT;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[s][k] >= w_dsh) begin
                        r_rem[s+1][k] <= r_rem[s][k] - w_dsh;
                        r_q[s+1][k]   <= r_q[s][k] | (DATA_W'(1) << BIT);
                    end else begin
                        r_rem[s+1][k] <= r_rem[s][k];
                        r_q[s+1][k]   <= r_q[s][k];
                    end
                end
                r_dd[s+1]  <= r_dd[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
                r_sng[s+1] <= r_sng[s];
            end
        end
    end

    // stage 40: sign, saturation and output register
    logic [DATA_W-1:0] n_sol [3];
    logic [DATA_W-1:0] r_sol [3];
    logic              r_status;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_sng[DIV_STEPS]) begin
                n_sol[k] = '0;
            end else if (r_neg[DIV_STEPS][k]) begin
                if (r_ovf[DIV_STEPS][k]
                        || (r_q[DIV_STEPS][k] > {1'b1, {(DATA_W-1){1'b0}}})) begin
                    n_sol[k] = {1'b1, {(DATA_W-1){1'b0}}};
                end else begin
                    n_sol[k] = DATA_W'(0) - r_q[DIV_STEPS][k];
                end
            end else begin
                if (r_ovf[DIV_STEPS][k] || r_q[DIV_STEPS][k][DATA_W-1]) begin
                    n_sol[k] = {1'b0, {(DATA_W-1){1'b1}}};
                end else begin
                    n_sol[k] = r_q[DIV_STEPS][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sol[k] <= n_sol[k];
            end
            r_status <= r_sng[DIV_STEPS] ? c3ls_pkg::STATUS_SINGULAR
                                         : c3ls_pkg::STATUS_SOLVED;
        end
    end

    assign o_out.valid  = r_vld[STAGES-1];
    assign o_out.sol1   = r_sol[0];
    assign o_out.sol2   = r_sol[1];
    assign o_out.sol3   = r_sol[2];
    assign o_out.status = r_status;

    // checks
    logic [REM_W-1:0] w_dext;
    logic             w_sol_zero;
    logic             w_last_div;
    logic             w_rem_low;
    assign w_dext     = {{(REM_W-NUM_W){1'b0}}, r_dd[DIV_STEPS]};
    assign w_sol_zero = (o_out.sol1 == '0) && (o_out.sol2 == '0) && (o_out.sol3 == '0);
    assign w_last_div = r_vld[STAGES-2] && !r_sng[DIV_STEPS] && !r_ovf[DIV_STEPS][0];
    assign w_rem_low  = r_rem[DIV_STEPS][0] < w_dext;

    `C3LS_ASSERT_SAME(a_singular_zero, i_clk, i_rst_n, o_out.valid && o_out.status, w_sol_zero)
    `C3LS_ASSERT_SAME(a_rem_below_div, i_clk, i_rst_n, w_last_div, w_rem_low)
    `C3LS_ASSERT_SAME(a_no_take_on_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    `C3LS_ASSERT_NEXT(a_take_reaches_pipe, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])

endmodule

// ----- sim/c3ls_checker.sv -----
// watches the solver channels, predicts each solution and compares results
module c3ls_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    c3ls_in_if    in_bus,
    c3ls_out_if   out_bus,
    c3ls_cfg_if   cfg_bus,
    output int    o_fail_count,
    output int    o_pending
);
    localparam int DATA_W = c3ls_pkg::DATA_W;
    localparam int THR_W  = c3ls_pkg::THR_W;
    localparam int FRAC_W = c3ls_pkg::FRAC_W;

    typedef logic signed [159:0] t_wide;

    typedef struct packed {
        logic signed [DATA_W-1:0] sol1;
        logic signed [DATA_W-1:0] sol2;
        logic signed [DATA_W-1:0] sol3;
        logic                     status;
    } t_solution;

    t_solution          solutions_due[$];
    logic [THR_W-1:0]   threshold;

    // truncating divide of a column determinant, saturated to q16.16
    function automatic logic signed [DATA_W-1:0] column_quotient(t_wide num, t_wide det);
        t_wide q;
        q = (num <<< FRAC_W) / det;
        if (q > 160'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (q < -160'sh80000000) return 32'sh80000000;
        return q[DATA_W-1:0];
    endfunction

    // exact cramer's rule on one system
    function automatic t_solution cramer_solve(logic signed [DATA_W-1:0] e [12],
                                               logic [THR_W-1:0] thr);
        t_wide x [12];
        t_wide c1, c2, c3, u1, u2, u3, u4, det, mag;
        t_solution r;
        for (int i = 0; i < 12; i++) x[i] = e[i];
        // x: m11 m12 m13 m21 m22 m23 m31 m32 m33 rhs1 rhs2 rhs3
        c1 = x[4] * x[8] - x[5] * x[7];
        c2 = x[3] * x[8] - x[5] * x[6];
        c3 = x[3] * x[7] - x[4] * x[6];
        u1 = x[10] * x[8] - x[11] * x[5];
        u2 = x[10] * x[7] - x[11] * x[4];
        u3 = x[3] * x[11] - x[6] * x[10];
        u4 = x[4] * x[11] - x[7] * x[10];
        det = x[0] * c1 - x[1] * c2 + x[2] * c3;
        mag = det < 0 ? -det : det;
        if (mag == 0 || (mag >>> 32) < $signed({129'b0, thr})) begin
            r = '{sol1: '0, sol2: '0, sol3: '0, status: c3ls_pkg::STATUS_SINGULAR};
        end else begin
            r.sol1   = column_quotient(x[9] * c1 - x[1] * u1 + x[2] * u2, det);
            r.sol2   = column_quotient(x[0] * u1 - x[9] * c2 + x[2] * u3, det);
            r.sol3   = column_quotient(x[0] * u4 - x[1] * u3 + x[9] * c3, det);
            r.status = c3ls_pkg::STATUS_SOLVED;
        end
        return r;
    endfunction

    assign o_pending = solutions_due.size();

    // predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] e [12];
        t_solution want;
        if (!i_rst_n) begin
            threshold    <= THR_W'(1);
            o_fail_count <= 0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) threshold <= cfg_bus.data;
            if (in_bus.valid && in_bus.ready) begin
                e = '{in_bus.m11, in_bus.m12, in_bus.m13, in_bus.m21, in_bus.m22,
                      in_bus.m23, in_bus.m31, in_bus.m32, in_bus.m33,
                      in_bus.rhs1, in_bus.rhs2, in_bus.rhs3};
                solutions_due.push_back(cramer_solve(e, threshold));
            end
            if (out_bus.valid && out_bus.ready) begin
                if (solutions_due.size() == 0) begin
                    $display("%0t: unexpected result sol=%h %h %h status=%b", $time,
                             out_bus.sol1, out_bus.sol2, out_bus.sol3, out_bus.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = solutions_due.pop_front();
                    if (want.sol1 !== out_bus.sol1 || want.sol2 !== out_bus.sol2 ||
                        want.sol3 !== out_bus.sol3 || want.status !== out_bus.status) begin
                        $display("%0t: mismatch expected sol=%h %h %h status=%b",
                                 $time, want.sol1, want.sol2, want.sol3, want.status);
                        $display("%0t:          actual   sol=%h %h %h status=%b",
                                 $time, out_bus.sol1, out_bus.sol2, out_bus.sol3,
                                 out_bus.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/testbench.sv -----
module testbench;
    localparam int DATA_W = c3ls_pkg::DATA_W;
    localparam int THR_W  = c3ls_pkg::THR_W;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PIPE_DRAIN  = 50;

    typedef enum int {SYS_WELL, SYS_FULL, SYS_SINGULAR, SYS_EXTREME} t_sys_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   no_idle;

    c3ls_in_if  in_bus ();
    c3ls_out_if out_bus ();
    c3ls_cfg_if cfg_bus ();

    cramer_3x3_linear_solve_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    c3ls_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_bus       (in_bus),
        .out_bus      (out_bus),
        .cfg_bus      (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // result receiver with random stalls
    initial begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk iff (out_bus.valid && out_bus.ready));
        end
    end

    // one system transfer, preceded by a random gap
    task automatic send_system(logic signed [DATA_W-1:0] e [12]);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        {in_bus.m11, in_bus.m12, in_bus.m13, in_bus.m21, in_bus.m22, in_bus.m23,
         in_bus.m31, in_bus.m32, in_bus.m33, in_bus.rhs1, in_bus.rhs2, in_bus.rhs3}
            <= {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
        @(posedge i_clk iff (in_bus.valid && in_bus.ready));
    endtask

    // threshold write once the pipe has drained
    task automatic write_threshold(logic [THR_W-1:0] thr);
        in_bus.valid <= 1'b0;
        @(posedge i_clk iff (pending == 0));
        repeat (PIPE_DRAIN) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= thr;
        @(posedge i_clk iff (cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] small_q16();
        return $signed($urandom_range(0, 1048576)) - 32'sd524288;
    endfunction

    function automatic logic signed [DATA_W-1:0] edge_q16();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh00010000;
            3: return 32'shFFFF0000;
            4: return 32'sh00000001;
            default: return '0;
        endcase
    endfunction

    task automatic send_random(t_sys_kind kind);
        logic signed [DATA_W-1:0] e [12];
        int k;
        for (int i = 0; i < 12; i++) begin
            case (kind)
                SYS_WELL:    e[i] = small_q16();
                SYS_FULL:    e[i] = $urandom();
                SYS_EXTREME: e[i] = $urandom_range(0, 1) ? edge_q16() : $urandom();
                default:     e[i] = small_q16();
            endcase
        end
        // dominant diagonal keeps most well-formed systems solvable
        if (kind == SYS_WELL && $urandom_range(0, 1)) begin
            e[0] = e[0] + 32'sh00100000;
            e[4] = e[4] - 32'sh00100000;
            e[8] = e[8] + 32'sh00100000;
        end
        // repeated row or column makes the determinant zero
        if (kind == SYS_SINGULAR) begin
            k = $urandom_range(0, 2);
            if ($urandom_range(0, 1))
                for (int c = 0; c < 3; c++) e[3 * ((k + 1) % 3) + c] = e[3 * k + c];
            else
                for (int r = 0; r < 3; r++) e[3 * r + (k + 1) % 3] = e[3 * r + k];
        end
        send_system(e);
    endtask

    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 5)       send_random(SYS_WELL);
            else if (pick < 7)  send_random(SYS_FULL);
            else if (pick < 8)  send_random(SYS_SINGULAR);
            else                send_random(SYS_EXTREME);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic signed [DATA_W-1:0] e [12];
        no_idle        = 1'b0;
        i_rst_n       <= 1'b0;
        in_bus.valid  <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= '0;
        {in_bus.m11, in_bus.m12, in_bus.m13, in_bus.m21, in_bus.m22, in_bus.m23,
         in_bus.m31, in_bus.m32, in_bus.m33, in_bus.rhs1, in_bus.rhs2, in_bus.rhs3} <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed systems at the reset threshold
        e = '{default: '0};
        send_system(e);
        e = '{default: 32'sh7FFFFFFF};
        send_system(e);
        e = '{default: 32'sh80000000};
        send_system(e);
        // identity with extreme right-hand side
        e = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000,
              32'sh7FFFFFFF, 32'sh80000000, 32'sh1};
        send_system(e);
        // tiny diagonal of both signs falls below the reset threshold, so singular
        e = '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, -32'sh100,
              32'sh7FFFFFFF, 32'sh80000000, 32'sh10000};
        send_system(e);
        // tiny diagonal just above and below the default threshold
        e = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh1, 5, 6, 7};
        send_system(e);
        e = '{32'sh10000, 0, 0, 0, 32'sh1, 0, 0, 0, 32'sh1, 5, 6, 7};
        send_system(e);
        // negative determinant, row swap
        e = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh20000,
              32'sh30000, -32'sh50000, 32'sh8000};
        send_system(e);
        // extremes on the anti-diagonal
        e = '{0, 0, 32'sh80000000, 0, 32'sh80000000, 0, 32'sh80000000, 0, 0,
              32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
        send_system(e);
        repeat (4) send_random(SYS_SINGULAR);
        repeat (4) send_random(SYS_EXTREME);

        // threshold settings, extremes among them
        write_threshold('0);
        e = '{32'sh10000, 0, 0, 0, 32'sh1, 0, 0, 0, 32'sh1, 5, 6, 7};
        send_system(e);
        send_random(SYS_SINGULAR);
        random_phase(300);

        write_threshold(31'h7FFFFFFF);
        random_phase(60);

        write_threshold(31'd65536);
        random_phase(300);

        write_threshold(THR_W'($urandom_range(0, 4096)));
        random_phase(300);

        write_threshold(31'd1);
        random_phase(270);

        in_bus.valid <= 1'b0;
        @(posedge i_clk iff (pending == 0));
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
